/* rtl/fixed_range_mtrr_unit_macros.svh */
// Assertion macros for the fixed-range MTRR unit.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef FIXED_RANGE_MTRR_UNIT_MACROS_SVH
`define FIXED_RANGE_MTRR_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define FRM_ASSERT_SAME(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("frmtrr: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define FRM_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("frmtrr: next-cycle check failed");

`endif

/* rtl/frmtrr_pkg.sv */
// Package for the fixed-range MTRR unit: item types, MSR numbers,
// register reset values and the fixed-range layout tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package frmtrr_pkg;

  localparam int FIXED_REGS  = 11;
  localparam int SUB_PER_REG = 8;

  // MSR numbers
  localparam logic [31:0] MSR_CAP           = 32'h0000_00FE;
  localparam logic [31:0] MSR_DEF_TYPE      = 32'h0000_02FF;
  localparam logic [31:0] MSR_FIX64K_00000  = 32'h0000_0250;
  localparam logic [31:0] MSR_FIX16K_80000  = 32'h0000_0258;
  localparam logic [31:0] MSR_FIX16K_A0000  = 32'h0000_0259;
  localparam logic [31:0] MSR_FIX4K_C0000   = 32'h0000_0268;
  localparam logic [31:0] MSR_FIX4K_C8000   = 32'h0000_0269;
  localparam logic [31:0] MSR_FIX4K_D0000   = 32'h0000_026A;
  localparam logic [31:0] MSR_FIX4K_D8000   = 32'h0000_026B;
  localparam logic [31:0] MSR_FIX4K_E0000   = 32'h0000_026C;
  localparam logic [31:0] MSR_FIX4K_E8000   = 32'h0000_026D;
  localparam logic [31:0] MSR_FIX4K_F0000   = 32'h0000_026E;
  localparam logic [31:0] MSR_FIX4K_F8000   = 32'h0000_026F;

  // Reset values and limits
  localparam logic [63:0] DEF_RESET   = 64'h0000_0000_0000_0C00;
  localparam logic [63:0] ALL_WB      = 64'h0606_0606_0606_0606;
  localparam logic [20:0] FIXED_LIMIT = 21'h10_0000;

  // Default-type register bits
  localparam int DEF_E_BIT  = 11;
  localparam int DEF_FE_BIT = 10;

  // Command kinds produced by the front decoder
  localparam logic [2:0] CMD_RD_CAP = 3'd0;
  localparam logic [2:0] CMD_RD_DEF = 3'd1;
  localparam logic [2:0] CMD_RD_FIX = 3'd2;
  localparam logic [2:0] CMD_WR_DEF = 3'd3;
  localparam logic [2:0] CMD_WR_FIX = 3'd4;
  localparam logic [2:0] CMD_BAD    = 3'd5;

  // Memory type codes
  localparam logic [2:0] MT_UC = 3'd0;
  localparam logic [2:0] MT_WC = 3'd1;
  localparam logic [2:0] MT_WT = 3'd4;
  localparam logic [2:0] MT_WP = 3'd5;
  localparam logic [2:0] MT_WB = 3'd6;

  typedef struct packed {
    logic        action;
    logic [31:0] msr_address;
    logic [63:0] write_data;
  } req_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        bad_address;
    logic        first_valid;
    logic [19:0] first_start;
    logic [20:0] first_size;
    logic [2:0]  first_type;
    logic        second_valid;
    logic [19:0] second_start;
    logic [20:0] second_size;
    logic [2:0]  second_type;
    logic        last;
  } rsp_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  fix_idx;
    logic [63:0] data;
  } cmd_t;

  // MTRR type byte to memory type code; reserved types fall to UC
  function automatic logic [2:0] ept_code(input logic [7:0] t);
    logic [2:0] code;
    case (t)
      8'd1:    code = MT_WC;
      8'd4:    code = MT_WT;
      8'd5:    code = MT_WP;
      8'd6:    code = MT_WB;
      default: code = MT_UC;
    endcase
    return code;
  endfunction

  // Base address of each fixed-range register
  function automatic logic [19:0] fix_base(input logic [3:0] r);
    logic [19:0] b;
    case (r)
      4'd0:    b = 20'h00000;
      4'd1:    b = 20'h80000;
      4'd2:    b = 20'hA0000;
      4'd3:    b = 20'hC0000;
      4'd4:    b = 20'hC8000;
      4'd5:    b = 20'hD0000;
      4'd6:    b = 20'hD8000;
      4'd7:    b = 20'hE0000;
      4'd8:    b = 20'hE8000;
      4'd9:    b = 20'hF0000;
      default: b = 20'hF8000;
    endcase
    return b;
  endfunction

  // log2 of the sub-range size: 64K, 16K or 4K
  function automatic logic [4:0] fix_shift(input logic [3:0] r);
    logic [4:0] s;
    case (r)
      4'd0:       s = 5'd16;
      4'd1, 4'd2: s = 5'd14;
      default:    s = 5'd12;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/frmtrr_front.sv */
// Front end of the fixed-range MTRR unit: accepts items and decodes the MSR
// number into a command kind and register index. Uses frmtrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frmtrr_front (
  input  wire logic             start,
  input  wire frmtrr_pkg::req_t req,
  input  wire logic             full,
  output logic                  busy,
  output logic                  push,
  output frmtrr_pkg::cmd_t      push_cmd
);
  import frmtrr_pkg::*;

  logic       is_fix;
  logic [3:0] fix_idx;

  // Accept whenever the queue has room
  assign busy = full;
  assign push = start && !full;

  // Fixed-range MSR number to register index
  always_comb begin
    is_fix  = 1'b1;
    fix_idx = 4'd0;
    case (req.msr_address)
      MSR_FIX64K_00000: fix_idx = 4'd0;
      MSR_FIX16K_80000: fix_idx = 4'd1;
      MSR_FIX16K_A0000: fix_idx = 4'd2;
      MSR_FIX4K_C0000:  fix_idx = 4'd3;
      MSR_FIX4K_C8000:  fix_idx = 4'd4;
      MSR_FIX4K_D0000:  fix_idx = 4'd5;
      MSR_FIX4K_D8000:  fix_idx = 4'd6;
      MSR_FIX4K_E0000:  fix_idx = 4'd7;
      MSR_FIX4K_E8000:  fix_idx = 4'd8;
      MSR_FIX4K_F0000:  fix_idx = 4'd9;
      MSR_FIX4K_F8000:  fix_idx = 4'd10;
      default:          is_fix  = 1'b0;
    endcase
  end

  // Classify the access; MTRRcap is read only
  always_comb begin
    push_cmd.fix_idx = fix_idx;
    push_cmd.data    = req.write_data;
    if (!req.action) begin
      if (req.msr_address == MSR_CAP)           push_cmd.kind = CMD_RD_CAP;
      else if (req.msr_address == MSR_DEF_TYPE) push_cmd.kind = CMD_RD_DEF;
      else if (is_fix)                          push_cmd.kind = CMD_RD_FIX;
      else                                      push_cmd.kind = CMD_BAD;
    end else begin
      if (req.msr_address == MSR_DEF_TYPE)      push_cmd.kind = CMD_WR_DEF;
      else if (is_fix)                          push_cmd.kind = CMD_WR_FIX;
      else                                      push_cmd.kind = CMD_BAD;
    end
  end

endmodule

`default_nettype wire

/* rtl/frmtrr_queue.sv */
// Command queue between front and back of the fixed-range MTRR unit.
// Small register FIFO; uses frmtrr_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module frmtrr_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire frmtrr_pkg::cmd_t push_cmd,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output frmtrr_pkg::cmd_t      head
);
  import frmtrr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/frmtrr_back.sv */
// Back end of the fixed-range MTRR unit: register file, capability bit,
// sub-range scanner and result register. Uses frmtrr_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_range_mtrr_unit_macros.svh"

module frmtrr_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_bit,
  input  wire logic             head_valid,
  input  wire frmtrr_pkg::cmd_t head,
  output logic                  pop,
  output logic                  rsp_valid,
  output frmtrr_pkg::rsp_t      rsp
);
  import frmtrr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic        state;
  logic        cap;
  logic [63:0] dflt_type;
  logic [63:0] fixed [FIXED_REGS];

  // Scanner position and the run being built
  logic [3:0]  scan_r;
  logic [2:0]  scan_j;
  logic        open;
  logic [19:0] run_start;
  logic [20:0] run_size;

  // First run of a pair waiting for its partner
  logic        pend_valid;
  logic [19:0] pend_start;
  logic [20:0] pend_size;
  logic [2:0]  pend_type;

  logic [3:0]  rd_idx;
  logic [63:0] rd_val;
  logic        def_changed;
  logic        scan_go;
  rsp_t        plain_rsp;

  logic [2:0]  j_next;
  logic [7:0]  sub_byte;
  logic [7:0]  next_byte;
  logic [4:0]  shift;
  logic [20:0] step;
  logic [20:0] offset;
  logic        run_end;
  logic        last_sub;
  logic [19:0] cur_start;
  logic [20:0] cur_size;
  logic [2:0]  cur_type;
  rsp_t        scan_rsp;

  // One read port on the register file, shared by reads and the scan
  assign rd_idx = (state == ST_SCAN) ? scan_r : head.fix_idx;
  assign rd_val = fixed[rd_idx];

  assign pop         = head_valid && (state == ST_IDLE);
  assign def_changed = (head.data != dflt_type);
  assign scan_go     = head.data[DEF_E_BIT] && head.data[DEF_FE_BIT] && cap;

  // Result for a command finished in one step
  always_comb begin
    plain_rsp      = '0;
    plain_rsp.last = 1'b1;
    case (head.kind)
      CMD_RD_CAP: plain_rsp.read_data = {55'd0, cap, 8'd0};
      CMD_RD_DEF: plain_rsp.read_data = dflt_type;
      CMD_RD_FIX: plain_rsp.read_data = rd_val;
      CMD_BAD:    plain_rsp.bad_address = 1'b1;
      CMD_WR_DEF: begin
        // whole first MiB with one type when E, FE or the capability bit is off
        if (def_changed && !scan_go) begin
          plain_rsp.first_valid = 1'b1;
          plain_rsp.first_size  = FIXED_LIMIT;
          plain_rsp.first_type  = head.data[DEF_E_BIT] ? ept_code(head.data[7:0]) : MT_UC;
        end
      end
      default: ;
    endcase
  end

  // Scan step: one sub-range per cycle, a run ends where the type changes or at the end of a register
  always_comb begin
    j_next    = scan_j + 3'd1;
    sub_byte  = rd_val[{scan_j, 3'b000} +: 8];
    next_byte = rd_val[{j_next, 3'b000} +: 8];
    shift     = fix_shift(scan_r);
    step      = 21'd1 << shift;
    offset    = 21'(scan_j) << shift;
    run_end   = (scan_j == 3'(SUB_PER_REG - 1)) || (next_byte != sub_byte);
    last_sub  = (scan_r == 4'(FIXED_REGS - 1)) && (scan_j == 3'(SUB_PER_REG - 1));
    cur_start = open ? run_start : fix_base(scan_r) + offset[19:0];
    cur_size  = open ? run_size + step : step;
    cur_type  = ept_code(sub_byte);

    scan_rsp             = '0;
    scan_rsp.first_valid = 1'b1;
    if (pend_valid) begin
      scan_rsp.first_start  = pend_start;
      scan_rsp.first_size   = pend_size;
      scan_rsp.first_type   = pend_type;
      scan_rsp.second_valid = 1'b1;
      scan_rsp.second_start = cur_start;
      scan_rsp.second_size  = cur_size;
      scan_rsp.second_type  = cur_type;
      scan_rsp.last         = last_sub;
    end else begin
      scan_rsp.first_start  = cur_start;
      scan_rsp.first_size   = cur_size;
      scan_rsp.first_type   = cur_type;
      scan_rsp.last         = 1'b1;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      rsp <= scan_rsp;
    end else begin
      rsp <= plain_rsp;
    end
  end

  // Control, register file and scanner
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rsp_valid  <= 1'b0;
      cap        <= 1'b1;
      dflt_type  <= DEF_RESET;
      for (int i = 0; i < FIXED_REGS; i++) begin
        fixed[i] <= ALL_WB;
      end
      scan_r     <= '0;
      scan_j     <= '0;
      open       <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      rsp_valid <= 1'b0;
      if (cfg_we) begin
        cap <= cfg_bit;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            rsp_valid <= 1'b1;
            if (head.kind == CMD_WR_FIX) begin
              fixed[head.fix_idx] <= head.data;
            end
            if (head.kind == CMD_WR_DEF && def_changed) begin
              dflt_type <= head.data;
              if (scan_go) begin
                rsp_valid  <= 1'b0;
                state      <= ST_SCAN;
                scan_r     <= '0;
                scan_j     <= '0;
                open       <= 1'b0;
                pend_valid <= 1'b0;
              end
            end
          end
        end
        ST_SCAN: begin
          if (run_end) begin
            open <= 1'b0;
            if (pend_valid || last_sub) begin
              rsp_valid  <= 1'b1;
              pend_valid <= 1'b0;
            end else begin
              pend_valid <= 1'b1;
              pend_start <= cur_start;
              pend_size  <= cur_size;
              pend_type  <= cur_type;
            end
          end else begin
            open      <= 1'b1;
            run_start <= cur_start;
            run_size  <= cur_size;
          end
          scan_j <= j_next;
          if (scan_j == 3'(SUB_PER_REG - 1)) begin
            scan_r <= scan_r + 4'd1;
          end
          if (last_sub) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `FRM_ASSERT_SAME(a_scan_no_pop, clk, rst, state == ST_SCAN, !pop)
  `FRM_ASSERT_NEXT(a_scan_ends, clk, rst, state == ST_SCAN && last_sub, state == ST_IDLE)
  `FRM_ASSERT_SAME(a_pair_order, clk, rst, rsp_valid && !rsp.first_valid, !rsp.second_valid)
  `FRM_ASSERT_SAME(a_bad_single, clk, rst, rsp_valid && rsp.bad_address, rsp.last && !rsp.first_valid)

endmodule

`default_nettype wire

/* rtl/fixed_range_mtrr_unit.sv */
// Top level of the fixed-range MTRR unit: front decoder, command queue and
// back end. Depends on frmtrr_pkg, frmtrr_front, frmtrr_queue, frmtrr_back.
//
//  channel  | signals                      | transfer
//  ---------+------------------------------+------------------------------
//  request  | start, busy, req             | edge with start && !busy
//  result   | rsp_valid, rsp               | one-cycle strobe per item, no stall
//  config   | cfg_valid, cfg_ready, cfg_data | edge with valid && ready
//
// A register read or write passes through the queue slot and the result
// register when the back end is free. A default-type change that enables the
// fixed ranges with the capability bit set walks the 88 sub-ranges one per
// cycle through the single register-file read port, giving up to 44 results.
// Requests queue up to QUEUE_DEPTH deep while a walk runs; busy is high when
// the queue is full. Synchronous reset restores all ranges to write-back.
`timescale 1ns / 1ps
`default_nettype none

module fixed_range_mtrr_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire frmtrr_pkg::req_t req,
  output logic                  rsp_valid,
  output frmtrr_pkg::rsp_t      rsp,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_data
);
  import frmtrr_pkg::*;

  logic full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head;

  // Capability bit is always writable
  assign cfg_ready = 1'b1;

  // Accept and classify
  frmtrr_front u_front (
    .start    (start),
    .req      (req),
    .full     (full),
    .busy     (busy),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouple decode from execution
  frmtrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Execute accesses and range walks
  frmtrr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_bit    (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire
